// ----- hdl/wsd_pkg.sv -----
// Shared types and constants for the stretched waveform drive with stillness detection.
package wsd_pkg;

  localparam int DIVIDEND_W = 19;
  localparam int DIVISOR_W  = 7;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int STRETCH_SCALE = 100;
  localparam int POSITIONS  = 1024;
  localparam int POS_W      = $clog2(POSITIONS);

  localparam logic [1:0] REG_STRETCH = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_PATTERN = 2'd2;

  localparam logic CMD_SAMPLE      = 1'b0;
  localparam logic CMD_TABLE_WRITE = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/stretched_waveform_pwm_still_detect.sv -----
// Top level: sample sequencing, table and ring memories, output register.
//
// A table write transaction is written while the block stays in IDLE. A position
// sample transaction runs the stretch division through a bit-serial divider (19
// quotient bits), takes the position modulo POSITIONS from the low quotient
// bits, reads the table and multiplies; the states DIV, TREAD, MUL and FINISH
// lie between the accepted sample and the load of the output register, and no
// new transaction is taken until the block is back in IDLE. When the ring is
// full and the hold counter allows it, the sample ring is first scanned in SCAN
// at one entry per cycle through its single read port. A result that finds the
// output register still held by a stalled result waits for it to leave.
// Neither memory needs clearing.
module stretched_waveform_pwm_still_detect #(
  parameter int WINDOW    = 512,
  parameter int PATTERNS  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [11:0]        sample,
  input  logic [9:0]         entry_position,
  input  logic [1:0]         entry_pattern,
  input  logic signed [7:0]  entry_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] drive_product,
  output logic               torque_off,
  output logic [9:0]         table_index,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int TDEPTH = wsd_pkg::POSITIONS * PATTERNS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int RAW    = $clog2(WINDOW);
  localparam int FW     = $clog2(WINDOW + 1);
  localparam int HW     = FW + 1;
  localparam int VW     = 13;

  typedef enum logic [5:0] {
    IDLE   = 6'b000001,
    DIV    = 6'b000010,
    TREAD  = 6'b000100,
    MUL    = 6'b001000,
    SCAN   = 6'b010000,
    FINISH = 6'b100000
  } state_t;

  function automatic logic [VW-1:0] mod_small(logic [VW-1:0] value, logic [VW-1:0] m);
    logic [VW-1:0] r;
    r = value;
    for (int i = 0; i < 4; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

  state_t                      state;
  logic [6:0]                  stretch_percent;
  logic [6:0]                  height_percent;
  logic [1:0]                  pattern_select;
  logic [RAW-1:0]              ring_pointer;
  logic [FW-1:0]               fill_count;
  logic signed [HW-1:0]        hold_counter;
  logic [11:0]                 sample_q;
  logic [wsd_pkg::POS_W-1:0]   pos_q;
  logic signed [14:0]          product_q;
  logic                        still;
  logic [FW-1:0]               scan_count;

  logic                  accept;
  logic                  full;
  logic                  hold_ok;
  logic                  near;
  logic                  zt;
  logic                  load_out;
  logic [VW-1:0]         wr_pos;
  logic [VW-1:0]         wr_pat;
  logic [VW-1:0]         rd_pat;
  logic [TAW-1:0]        tbl_waddr;
  logic [TAW-1:0]        tbl_raddr;
  logic signed [7:0]     tbl_rdata;
  logic [11:0]           ring_rdata;
  logic                  ring_read;
  logic [12:0]           v_ext;
  logic [12:0]           s_ext;
  logic signed [15:0]    product_full;
  wsd_pkg::div_req_t     div_req;
  wsd_pkg::div_rsp_t     div_rsp;

  assign in_stall = state != IDLE;
  assign accept   = in_valid && !in_stall;
  assign full     = fill_count == FW'(WINDOW);
  assign hold_ok  = hold_counter == HW'(WINDOW) || hold_counter == '1;

  assign wr_pos    = mod_small(VW'(entry_position), VW'(wsd_pkg::POSITIONS));
  assign wr_pat    = mod_small(VW'(entry_pattern), VW'(PATTERNS));
  assign rd_pat    = mod_small(VW'(pattern_select), VW'(PATTERNS));
  assign tbl_waddr = TAW'(int'(wr_pos) * PATTERNS + int'(wr_pat));
  assign tbl_raddr = TAW'(int'(pos_q) * PATTERNS + int'(rd_pat));

  wsd_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_table (
    .clk           (clk),
    .write_enable  (accept && cmd == wsd_pkg::CMD_TABLE_WRITE),
    .write_address (tbl_waddr),
    .write_data    (entry_value),
    .read_enable   (state == TREAD),
    .read_address  (tbl_raddr),
    .read_data     (tbl_rdata)
  );

  assign ring_read = state == SCAN && scan_count < FW'(WINDOW);

  wsd_ram #(.WIDTH(12), .DEPTH(WINDOW)) u_ring (
    .clk           (clk),
    .write_enable  (accept && cmd == wsd_pkg::CMD_SAMPLE),
    .write_address (ring_pointer),
    .write_data    (sample),
    .read_enable   (ring_read),
    .read_address  (scan_count[RAW-1:0]),
    .read_data     (ring_rdata)
  );

  always_comb begin
    div_req.start    = accept && cmd == wsd_pkg::CMD_SAMPLE;
    div_req.dividend = wsd_pkg::DIVIDEND_W'(int'(sample) * wsd_pkg::STRETCH_SCALE);
    div_req.divisor  = (stretch_percent == '0) ? wsd_pkg::DIVISOR_W'(1)
                                               : wsd_pkg::DIVISOR_W'(stretch_percent);
  end

  wsd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign product_full = 16'(tbl_rdata) * 16'($signed({1'b0, height_percent}));
  assign v_ext = {1'b0, ring_rdata};
  assign s_ext = {1'b0, sample_q};
  assign near  = !((v_ext + 13'd1 < s_ext) || (v_ext > s_ext + 13'd1));
  assign zt       = full && hold_ok && still;
  assign load_out = state == FINISH && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_percent <= 7'd100;
      height_percent  <= 7'd100;
      pattern_select  <= 2'd0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        wsd_pkg::REG_STRETCH: stretch_percent <= cfg_data;
        wsd_pkg::REG_HEIGHT:  height_percent  <= cfg_data;
        wsd_pkg::REG_PATTERN: pattern_select  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      ring_pointer <= '0;
      fill_count   <= '0;
      hold_counter <= '1;
      out_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept && cmd == wsd_pkg::CMD_SAMPLE) begin
            ring_pointer <= (ring_pointer == RAW'(WINDOW - 1)) ? '0 : ring_pointer + 1'b1;
            if (fill_count < FW'(WINDOW)) begin
              fill_count <= fill_count + 1'b1;
            end
            state <= DIV;
          end
        end
        DIV: begin
          if (div_rsp.done) begin
            state <= TREAD;
          end
        end
        TREAD: begin
          state <= MUL;
        end
        MUL: begin
          state <= (full && hold_ok) ? SCAN : FINISH;
        end
        SCAN: begin
          if (scan_count == FW'(WINDOW)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (load_out) begin
            if (full) begin
              if (zt) begin
                hold_counter <= HW'(WINDOW);
              end else if (hold_counter != '1) begin
                hold_counter <= hold_counter - 1'b1;
              end
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == wsd_pkg::CMD_SAMPLE) begin
      sample_q <= sample;
    end
    if (state == DIV && div_rsp.done) begin
      pos_q <= div_rsp.quotient[wsd_pkg::POS_W-1:0];
    end
    if (state == MUL) begin
      product_q  <= product_full[14:0];
      still      <= full && hold_ok;
      scan_count <= '0;
    end
    if (state == SCAN) begin
      scan_count <= scan_count + 1'b1;
      if (scan_count != '0 && !near) begin
        still <= 1'b0;
      end
    end
    if (load_out) begin
      drive_product <= zt ? 15'sd0 : product_q;
      torque_off    <= zt;
      table_index   <= pos_q;
    end
  end

endmodule

// ----- hdl/wsd_ram.sv -----
// Single-port-write, registered-read synchronous memory.
module wsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     write_enable,
  input  logic [$clog2(DEPTH)-1:0] write_address,
  input  logic [WIDTH-1:0]         write_data,
  input  logic                     read_enable,
  input  logic [$clog2(DEPTH)-1:0] read_address,
  output logic [WIDTH-1:0]         read_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write_enable) begin
      mem[write_address] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (read_enable) begin
      read_data <= mem[read_address];
    end
  end

endmodule

// ----- hdl/wsd_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module wsd_div (
  input  logic              clk,
  input  logic              rst,
  input  wsd_pkg::div_req_t req,
  output wsd_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [wsd_pkg::DIV_CNT_W-1:0]     count;
  logic [wsd_pkg::DIVIDEND_W-1:0]    work;
  logic [wsd_pkg::DIVISOR_W-1:0]     divisor;
  logic [wsd_pkg::DIVISOR_W:0]       rem;
  logic [wsd_pkg::DIVISOR_W:0]       rem_shift;
  logic                              fits;

  assign rem_shift = {rem[wsd_pkg::DIVISOR_W-1:0], work[wsd_pkg::DIVIDEND_W-1]};
  assign fits = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == wsd_pkg::DIV_CNT_W'(wsd_pkg::DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      count   <= '0;
      work    <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      work  <= {work[wsd_pkg::DIVIDEND_W-2:0], fits};
      rem   <= fits ? rem_shift - {1'b0, divisor} : rem_shift;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = work;

endmodule

// ----- tb/tb_stretched_waveform_pwm_still_detect.sv -----
// Self-checking testbench for the stretched waveform drive with stillness detection.
module tb_stretched_waveform_pwm_still_detect;

  localparam int RING_DEPTH      = 512;
  localparam int TABLE_POSITIONS = wsd_pkg::POSITIONS;
  localparam int TABLE_PATTERNS  = 4;
  localparam int TABLE_SLOTS     = TABLE_POSITIONS * TABLE_PATTERNS;

  localparam int RANDOM_ITEMS    = 750;
  localparam int STILL_RUN       = 540;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 600;
  localparam int STALL_LIMIT     = 20000;

  typedef struct packed {
    logic signed [14:0] product;
    logic               zt;
    logic [9:0]         index;
  } drive_result_t;

  class drive_tracker;
    logic signed [7:0] wave_tbl [TABLE_SLOTS];
    bit                entry_set [TABLE_SLOTS];
    logic [11:0]       pos_ring [RING_DEPTH];
    int unsigned       ring_fill;
    int unsigned       ring_ptr;
    int                hold_count;
    logic [6:0]        stretch;
    logic [6:0]        height;
    logic [1:0]        pattern;
    drive_result_t     expected_q [$];
    int                failures;

    function new();
      ring_fill  = 0;
      ring_ptr   = 0;
      hold_count = -1;
      stretch    = 7'd100;
      height     = 7'd100;
      pattern    = 2'd0;
      failures   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        wsd_pkg::REG_STRETCH: stretch = val;
        wsd_pkg::REG_HEIGHT:  height  = val;
        wsd_pkg::REG_PATTERN: pattern = val[1:0];
        default: ;
      endcase
    endfunction

    function int unsigned stretched_position(logic [11:0] s);
      int unsigned div;
      int unsigned scaled;
      div    = (stretch == 0) ? 1 : int'(stretch);
      scaled = 32'(s);
      return ((scaled * 100) / div) % TABLE_POSITIONS;
    endfunction

    function int unsigned table_slot(logic [11:0] s);
      return stretched_position(s) * TABLE_PATTERNS + 32'(pattern);
    endfunction

    function bit window_still(logic [11:0] s);
      int unsigned cur;
      int unsigned v;
      cur = 32'(s);
      for (int i = 0; i < RING_DEPTH; i++) begin
        v = 32'(pos_ring[i]);
        if (v + 1 < cur || v > cur + 1) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_item(logic c, logic [11:0] s, logic [9:0] epos, logic [1:0] epat,
                            logic signed [7:0] eval);
      int            slot;
      int            prod;
      drive_result_t want;
      if (c == wsd_pkg::CMD_TABLE_WRITE) begin
        slot = int'(epos) * TABLE_PATTERNS + int'(epat);
        wave_tbl[slot]  = eval;
        entry_set[slot] = 1'b1;
        return;
      end
      pos_ring[ring_ptr] = s;
      ring_ptr = (ring_ptr + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
      slot = table_slot(s);
      prod = int'(wave_tbl[slot]) * int'(height);
      want.zt = 1'b0;
      if (ring_fill >= RING_DEPTH) begin
        if ((hold_count == RING_DEPTH || hold_count < 0) && window_still(s)) begin
          prod       = 0;
          want.zt    = 1'b1;
          hold_count = RING_DEPTH;
        end else if (hold_count > -1) begin
          hold_count--;
        end
      end
      want.product = prod[14:0];
      want.index   = 10'(stretched_position(s));
      expected_q.push_back(want);
    endfunction

    function void check_result(logic signed [14:0] prod, logic zt, logic [9:0] idx);
      drive_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected drive result: drive_product %0d torque_off %0b table_index %0d",
               prod, zt, idx);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (prod !== want.product) begin
        $error("drive_product expected %0d actual %0d", want.product, prod);
        failures++;
      end
      if (zt !== want.zt) begin
        $error("torque_off expected %0b actual %0b", want.zt, zt);
        failures++;
      end
      if (idx !== want.index) begin
        $error("table_index expected %0d actual %0d", want.index, idx);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic [11:0]        sample;
  logic [9:0]         entry_position;
  logic [1:0]         entry_pattern;
  logic signed [7:0]  entry_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [14:0] drive_product;
  logic               torque_off;
  logic [9:0]         table_index;
  logic               cfg_write_enable;
  logic [1:0]         cfg_index;
  logic [6:0]         cfg_data;

  drive_tracker tracker = new();
  int           send_idle_pct = 11;
  int           recv_idle_pct = 67;
  int           stall_hold = 0;
  int           items_sent = 0;
  int           stuck_cycles;

  stretched_waveform_pwm_still_detect #(
    .WINDOW(RING_DEPTH),
    .PATTERNS(TABLE_PATTERNS)
  ) u_top (.*);

  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall = 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      tracker.check_result(drive_product, torque_off, table_index);
    end
  end

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(input logic c, input logic [11:0] s, input logic [9:0] epos,
                           input logic [1:0] epat, input logic signed [7:0] eval);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    cmd            = c;
    sample         = s;
    entry_position = epos;
    entry_pattern  = epat;
    entry_value    = eval;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.take_item(c, s, epos, epat, eval);
    items_sent++;
  endtask

  task automatic write_entry(input int pos, input int pat, input int val);
    send_item(wsd_pkg::CMD_TABLE_WRITE, 12'($urandom_range(0, 4095)), 10'(pos), 2'(pat),
              8'(val));
  endtask

  task automatic send_sample(input int s);
    int unsigned slot;
    slot = tracker.table_slot(12'(s));
    if (!tracker.entry_set[slot]) begin
      write_entry(slot / TABLE_PATTERNS, slot % TABLE_PATTERNS, $urandom_range(0, 255));
    end
    send_item(wsd_pkg::CMD_SAMPLE, 12'(s), 10'($urandom_range(0, 1023)),
              2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic drain_block(input int pause);
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_index        = idx;
    cfg_data         = 7'(val);
    @(negedge clk);
    cfg_write_enable = 1'b0;
    tracker.set_reg(idx, 7'(val));
  endtask

  task automatic configure(input int stretch_val, input int height_val, input int pattern_val);
    drain_block(SETTLE_CYCLES);
    write_reg(wsd_pkg::REG_STRETCH, stretch_val);
    write_reg(wsd_pkg::REG_HEIGHT, height_val);
    write_reg(wsd_pkg::REG_PATTERN, pattern_val);
  endtask

  initial begin
    int phase;
    int phase_end;
    int random_start;
    int samples_drawn;
    int run_base;
    int seg_base;
    int seg_left;
    bit seg_still;
    int s;

    rst              = 1'b1;
    in_valid         = 1'b0;
    cmd              = wsd_pkg::CMD_SAMPLE;
    sample           = '0;
    entry_position   = '0;
    entry_pattern    = '0;
    entry_value      = '0;
    out_stall        = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index        = wsd_pkg::REG_STRETCH;
    cfg_data         = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    configure(100, 100, 0);
    write_entry(0, 0, 127);
    write_entry(1023, 0, -128);
    write_entry(1023, 3, -1);
    write_entry(5, 2, 1);
    send_sample(0);
    send_sample(4095);
    send_sample(1023);

    configure(0, 127, 3);
    write_entry(0, 3, -128);
    send_sample(0);
    send_sample(4095);
    send_sample(1);

    configure(1, 0, 1);
    send_sample(2048);
    send_sample(4095);

    configure(100, 100, 2);
    send_sample(5);

    random_start  = items_sent;
    samples_drawn = 0;
    seg_left      = 0;
    seg_still     = 1'b0;
    seg_base      = 0;
    run_base      = $urandom_range(0, 4093);
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          configure($urandom_range(1, 100), $urandom_range(0, 100), $urandom_range(0, 3));
          send_idle_pct = 11;
          recv_idle_pct = 67;
          phase_end = random_start + 250;
        end
        1: begin
          configure($urandom_range(101, 127), 127, $urandom_range(0, 127));
          send_idle_pct = 67;
          recv_idle_pct = 11;
          phase_end = random_start + 620;
        end
        default: begin
          configure($urandom_range(0, 3), $urandom_range(0, 127), $urandom_range(0, 3));
          send_idle_pct = 0;
          recv_idle_pct = 0;
          stall_hold = HOLD_OFF_CYCLES;
          phase_end = random_start + RANDOM_ITEMS;
        end
      endcase
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 8) begin
          write_entry($urandom_range(0, 1023), $urandom_range(0, 3), $urandom_range(0, 255));
        end else begin
          // A long still run fills the ring and holds it still; one sample two steps
          // off then breaks the window, and mixed noise and short runs follow.
          if (samples_drawn < STILL_RUN) begin
            s = run_base + $urandom_range(0, 1);
          end else if (samples_drawn == STILL_RUN) begin
            s = run_base + 2;
          end else begin
            if (seg_left == 0) begin
              seg_still = 1'($urandom_range(0, 1));
              seg_left  = $urandom_range(1, 40);
              seg_base  = $urandom_range(0, 4094);
            end
            s = seg_still ? seg_base + $urandom_range(0, 1) : $urandom_range(0, 4095);
            seg_left--;
          end
          send_sample(s);
          samples_drawn++;
        end
      end
    end

    drain_block(DRAIN_CYCLES);
    if (tracker.failures == 0 && tracker.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
